>>> src/ctf_pkg.sv
// Shared types and constants for the CSV field tokenizer.
`timescale 1ns / 1ps

package ctf_pkg;

	// Default parameter values
	localparam int OFFSET_BITS_DEF     = 24;
	localparam int NULL_COUNT_BITS_DEF = 8;

	// Result queue depth; an item may push two results
	localparam int RES_DEPTH = 4;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// Result kinds
	localparam logic [1:0] KIND_FIELD   = 2'd0;
	localparam logic [1:0] KIND_ROW_END = 2'd1;
	localparam logic [1:0] KIND_DISCARD = 2'd2;

	// Parse modes
	typedef enum logic [2:0] {
		MODE_EXPECT      = 3'd0,
		MODE_PLAIN       = 3'd1,
		MODE_QUOTED      = 3'd2,
		MODE_QUOTE_SEEN  = 3'd3,
		MODE_AFTER_QUOTE = 3'd4
	} mode_t;

	// One input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	// One result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] field_start;
		logic [23:0] field_length;
		logic        null_field;
		logic        was_quoted;
		logic [7:0]  leading_nulls;
		logic        malformed;
		logic        last_of_run;
	} out_item_t;

	// Results produced by one parse step, in order
	typedef struct packed {
		logic      v0;
		logic      v1;
		out_item_t r0;
		out_item_t r1;
	} res_pair_t;

endpackage

>>> src/csv_field_tokenizer.sv
// A byte's first result goes through the input register and result queue, behind any queued.
// One byte per cycle while byte_stall is low; a byte yields zero to two results, queued four deep.
// byte_stall rises only while the result queue cannot take two more items.
// Reset (arst_n low) clears parse state, byte offset and the queue at once.
// Top level: input register, parse step and result queue.
`timescale 1ns / 1ps

module csv_field_tokenizer #(
	parameter int OFFSET_BITS     = ctf_pkg::OFFSET_BITS_DEF,
	parameter int NULL_COUNT_BITS = ctf_pkg::NULL_COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  ctf_pkg::in_item_t   byte_item,
	output logic                tok_valid,
	input  logic                tok_stall,
	output ctf_pkg::out_item_t  tok_item
);
	import ctf_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      room;
	logic      step;
	res_pair_t pair;

	assign step       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;

	// Load the input register whenever it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	ctf_parser #(
		.OB(OFFSET_BITS),
		.NB(NULL_COUNT_BITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.pair   (pair)
	);

	ctf_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair),
		.room   (room),
		.valid  (tok_valid),
		.stall  (tok_stall),
		.data   (tok_item)
	);

endmodule

>>> src/ctf_parser.sv
// Per-byte parse step: row/field state and the results of one byte.
`timescale 1ns / 1ps

module ctf_parser #(
	parameter int OB = ctf_pkg::OFFSET_BITS_DEF,
	parameter int NB = ctf_pkg::NULL_COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  ctf_pkg::in_item_t   item,
	output ctf_pkg::res_pair_t  pair
);
	import ctf_pkg::*;

	typedef struct packed {
		mode_t          mode;
		logic           esc;
		logic [OB-1:0]  off;
		logic [OB-1:0]  span;
		logic [OB-1:0]  tlen;
		logic [NB-1:0]  ncnt;
		logic           rhf;
		logic           aw;
	} state_t;

	state_t    st_q;
	state_t    s;
	logic      fv, endr, disc, ev, aq;
	out_item_t fr, er;
	logic [7:0] b;
	logic       last;
	logic       is_white, is_comma, is_eol, is_quote, is_bs;
	logic [OB-1:0] here, incl;

	function automatic out_item_t mk(logic [1:0] kind, logic [OB-1:0] start,
			logic [OB-1:0] len, logic nul, logic q, logic [NB-1:0] lead, logic bad);
		out_item_t r;
		r.kind          = kind;
		r.field_start   = 24'(start);
		r.field_length  = 24'(len);
		r.null_field    = nul;
		r.was_quoted    = q;
		r.leading_nulls = 8'(lead);
		r.malformed     = bad;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	function automatic state_t clear_row(state_t x);
		state_t t;
		t      = x;
		t.mode = MODE_EXPECT;
		t.esc  = 1'b0;
		t.ncnt = '0;
		t.rhf  = 1'b0;
		t.aw   = 1'b0;
		return t;
	endfunction

	// Open a quoted or plain field on a content byte
	function automatic state_t begin_field(state_t x, logic [7:0] c);
		state_t t;
		t    = x;
		t.aw = 1'b0;
		if (c == CH_QUOTE) begin
			t.span = x.off + OB'(1);
			t.mode = MODE_QUOTED;
		end else begin
			t.span = x.off;
			t.mode = MODE_PLAIN;
			t.tlen = OB'(1);
			t.esc  = (c == CH_BSLASH);
		end
		return t;
	endfunction

	// Classify the byte
	assign b        = item.data_byte;
	assign last     = item.end_of_data;
	assign is_white = (b == CH_SPACE) || (b == CH_TAB);
	assign is_comma = (b == CH_COMMA);
	assign is_eol   = (b == CH_LF) || (b == CH_CR) || (b == CH_NUL);
	assign is_quote = (b == CH_QUOTE);
	assign is_bs    = (b == CH_BSLASH);
	assign here     = st_q.off - st_q.span;
	assign incl     = here + OB'(1);
	assign aq       = (st_q.mode == MODE_AFTER_QUOTE) ||
	                  ((st_q.mode == MODE_QUOTE_SEEN) && !is_quote);

	// Next state and results of one byte
	always_comb begin
		s    = st_q;
		fv   = 1'b0;
		fr   = '0;
		endr = 1'b0;
		disc = 1'b0;
		if (aq) begin
			s.mode = MODE_AFTER_QUOTE;
			if (is_white) begin
				if (last) begin
					fv = 1'b1;
					fr = mk(KIND_FIELD, s.span, s.tlen, 1'b0, 1'b1,
					        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b0);
					s.rhf = 1'b1;
					endr  = 1'b1;
				end
			end else if (is_comma || is_eol) begin
				fv = 1'b1;
				fr = mk(KIND_FIELD, s.span, s.tlen, 1'b0, 1'b1,
				        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b0);
				s.rhf = 1'b1;
				if (is_comma) begin
					s.mode = MODE_EXPECT;
					s.aw   = 1'b0;
					endr   = last;
				end else begin
					endr = 1'b1;
				end
			end else begin
				fv = 1'b1;
				fr = mk(KIND_FIELD, s.span, s.tlen, 1'b0, 1'b1,
				        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b1);
				s.rhf  = 1'b1;
				s.mode = MODE_EXPECT;
				s.aw   = 1'b0;
				if (last) begin
					disc = is_bs;
					endr = !is_bs;
				end else begin
					s = begin_field(s, b);
				end
			end
		end else begin
			case (st_q.mode)
				MODE_PLAIN: begin
					if (!s.esc && (is_comma || is_eol)) begin
						fv = 1'b1;
						fr = mk(KIND_FIELD, s.span, s.tlen, 1'b0, 1'b0,
						        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b0);
						s.rhf = 1'b1;
						if (is_comma) begin
							s.mode = MODE_EXPECT;
							s.aw   = 1'b0;
							endr   = last;
						end else begin
							endr = 1'b1;
						end
					end else begin
						if (!is_white) begin
							s.tlen = incl;
						end
						if (!s.esc && is_bs) begin
							s.esc = 1'b1;
							disc  = last;
						end else begin
							s.esc = 1'b0;
							if (last) begin
								fv = 1'b1;
								fr = mk(KIND_FIELD, s.span, s.tlen, 1'b0, 1'b0,
								        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b0);
								s.rhf = 1'b1;
								endr  = 1'b1;
							end
						end
					end
				end
				MODE_QUOTED: begin
					if (s.esc || !(is_quote || is_eol || is_bs)) begin
						s.esc = 1'b0;
						if (last) begin
							fv = 1'b1;
							fr = mk(KIND_FIELD, s.span, incl, 1'b0, 1'b1,
							        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b1);
							s.rhf = 1'b1;
							endr  = 1'b1;
						end
					end else if (is_quote) begin
						s.tlen = here;
						s.mode = MODE_QUOTE_SEEN;
						if (last) begin
							fv = 1'b1;
							fr = mk(KIND_FIELD, s.span, here, 1'b0, 1'b1,
							        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b0);
							s.rhf = 1'b1;
							endr  = 1'b1;
						end
					end else if (is_eol) begin
						fv = 1'b1;
						fr = mk(KIND_FIELD, s.span, here, 1'b0, 1'b1,
						        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b1);
						s.rhf = 1'b1;
						endr  = 1'b1;
					end else begin
						s.esc = 1'b1;
						disc  = last;
					end
				end
				MODE_QUOTE_SEEN: begin
					// Doubled quote: stay in the quoted field
					s.mode = MODE_QUOTED;
					if (last) begin
						fv = 1'b1;
						fr = mk(KIND_FIELD, s.span, incl, 1'b0, 1'b1,
						        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b1);
						s.rhf = 1'b1;
						endr  = 1'b1;
					end
				end
				default: begin
					s.mode = MODE_EXPECT;
					s.esc  = 1'b0;
					if (is_white) begin
						s.aw = 1'b1;
						if (last) begin
							fv = 1'b1;
							fr = mk(KIND_FIELD, s.off + OB'(1), '0, 1'b0, 1'b0,
							        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b0);
							s.rhf = 1'b1;
							endr  = 1'b1;
						end
					end else if (is_comma) begin
						s.aw = 1'b0;
						if (s.rhf) begin
							fv = 1'b1;
							fr = mk(KIND_FIELD, s.off, '0, 1'b1, 1'b0, {NB{1'b0}}, 1'b0);
						end else if (s.ncnt != {NB{1'b1}}) begin
							s.ncnt = s.ncnt + NB'(1);
						end
						endr = last;
					end else if (is_eol) begin
						if (s.aw) begin
							fv = 1'b1;
							fr = mk(KIND_FIELD, s.off, '0, 1'b0, 1'b0,
							        s.rhf ? {NB{1'b0}} : s.ncnt, 1'b0);
							s.rhf = 1'b1;
						end
						endr = 1'b1;
					end else begin
						s = begin_field(s, b);
						if (last) begin
							if (is_bs) begin
								disc = 1'b1;
							end else begin
								fv = 1'b1;
								fr = mk(KIND_FIELD, s.span, is_quote ? '0 : OB'(1),
								        1'b0, is_quote, s.rhf ? {NB{1'b0}} : s.ncnt,
								        is_quote);
								s.rhf = 1'b1;
								endr  = 1'b1;
							end
						end
					end
				end
			endcase
		end

		// Close the row: row end only if it held a real field
		ev = disc || (endr && s.rhf);
		er = mk(disc ? KIND_DISCARD : KIND_ROW_END, '0, '0, 1'b0, 1'b0, '0, 1'b0);
		er.last_of_run = 1'b1;
		if (disc || endr) begin
			s = clear_row(s);
		end
		s.off = last ? '0 : (st_q.off + OB'(1));

		fr.last_of_run = !ev;
		pair.v0 = step && (fv || ev);
		pair.v1 = step && fv && ev;
		pair.r0 = fv ? fr : er;
		pair.r1 = er;
	end

	// Hold state between accepted items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode <= MODE_EXPECT;
			st_q.esc  <= 1'b0;
			st_q.off  <= '0;
			st_q.span <= '0;
			st_q.tlen <= '0;
			st_q.ncnt <= '0;
			st_q.rhf  <= 1'b0;
			st_q.aw   <= 1'b0;
		end else if (step) begin
			st_q <= s;
		end
	end

`ifndef SYNTH
	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		pair.v1 |-> pair.v0)
		else $error("second result without a first");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		pair.v1 |-> (pair.r0.kind == KIND_FIELD) && (pair.r1.kind != KIND_FIELD))
		else $error("two results not a field followed by a row result");
	a_offset_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.end_of_data) |=> (st_q.off == '0))
		else $error("offset not cleared after last byte");
`endif

endmodule

>>> src/ctf_res_fifo.sv
// Small result queue: takes up to two items a cycle, delivers one while not stalled.
`timescale 1ns / 1ps

module ctf_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  ctf_pkg::res_pair_t  pair,
	output logic                room,
	output logic                valid,
	input  logic                stall,
	output ctf_pkg::out_item_t  data
);
	import ctf_pkg::*;

	localparam int PW = $clog2(RES_DEPTH);
	localparam int CW = $clog2(RES_DEPTH + 1);

	out_item_t      mem_q [RES_DEPTH];
	logic [PW-1:0]  wp_q, rp_q, wp1;
	logic [CW-1:0]  count_q;
	logic           pop;
	logic [1:0]     npush;

	function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
		return (p == PW'(RES_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wp1   = inc(wp_q);
	assign valid = (count_q != '0);
	assign data  = mem_q[rp_q];
	assign pop   = valid && !stall;
	assign room  = (count_q <= CW'(RES_DEPTH - 2));
	assign npush = {1'b0, pair.v0} + {1'b0, pair.v1};

	// Store pushed items
	always_ff @(posedge clk) begin
		if (pair.v0) begin
			mem_q[wp_q] <= pair.r0;
		end
		if (pair.v1) begin
			mem_q[wp1] <= pair.r1;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (pair.v1) begin
				wp_q <= inc(wp1);
			end else if (pair.v0) begin
				wp_q <= wp1;
			end
			if (pop) begin
				rp_q <= inc(rp_q);
			end
			count_q <= count_q + CW'(npush) - CW'(pop);
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RES_DEPTH))
		else $error("result queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		pair.v0 |-> room)
		else $error("push without room for two items");
`endif

endmodule

>>> sim/tb_csv_field_tokenizer.sv
// Testbench for the CSV field tokenizer: random and directed byte streams, tokens checked in order.
`timescale 1ns / 1ps

module tb_csv_field_tokenizer;
	import ctf_pkg::*;

	// Tracks tokenizer state per accepted byte and holds the tokens it predicts
	class token_scoreboard;
		mode_t       mode;
		bit          esc;
		bit [23:0]   offset;
		bit [23:0]   span_start;
		bit [23:0]   trim_len;
		bit [7:0]    null_cnt;
		bit          row_open;
		bit          saw_white;
		out_item_t   expected_tokens[$];
		int          mismatches;

		function new();
			mode = MODE_EXPECT;
			esc = 0;
			offset = 0;
			span_start = 0;
			trim_len = 0;
			null_cnt = 0;
			row_open = 0;
			saw_white = 0;
			mismatches = 0;
		endfunction

		function bit is_white(logic [7:0] b);
			return b == CH_SPACE || b == CH_TAB;
		endfunction

		function bit is_eol(logic [7:0] b);
			return b == CH_LF || b == CH_CR || b == CH_NUL;
		endfunction

		function void push_token(logic [1:0] kind, logic [23:0] start, logic [23:0] len,
				bit nul, bit quoted, logic [7:0] lead, bit bad);
			out_item_t t;
			t.kind = kind;
			t.field_start = start;
			t.field_length = len;
			t.null_field = nul;
			t.was_quoted = quoted;
			t.leading_nulls = lead;
			t.malformed = bad;
			t.last_of_run = 1'b0;
			expected_tokens.push_back(t);
		endfunction

		// Report a real field; the first one of a row carries the null count
		function void push_field(logic [23:0] start, logic [23:0] len, bit quoted, bit bad);
			push_token(KIND_FIELD, start, len, 1'b0, quoted, row_open ? 8'd0 : null_cnt, bad);
			row_open = 1;
		endfunction

		function void clear_row();
			mode = MODE_EXPECT;
			esc = 0;
			null_cnt = 0;
			row_open = 0;
			saw_white = 0;
		endfunction

		function void close_row();
			if (row_open)
				push_token(KIND_ROW_END, '0, '0, 1'b0, 1'b0, '0, 1'b0);
			clear_row();
		endfunction

		function void drop_row();
			push_token(KIND_DISCARD, '0, '0, 1'b0, 1'b0, '0, 1'b0);
			clear_row();
		endfunction

		// Byte where a field is expected
		function void begin_field(logic [7:0] b, bit eod);
			if (is_white(b)) begin
				saw_white = 1;
				if (eod) begin
					push_field(offset + 24'd1, '0, 1'b0, 1'b0);
					close_row();
				end
			end else if (b == CH_COMMA) begin
				saw_white = 0;
				if (row_open)
					push_token(KIND_FIELD, offset, '0, 1'b1, 1'b0, '0, 1'b0);
				else if (null_cnt != 8'hFF)
					null_cnt++;
				if (eod)
					close_row();
			end else if (is_eol(b)) begin
				if (saw_white)
					push_field(offset, '0, 1'b0, 1'b0);
				close_row();
			end else if (b == CH_QUOTE) begin
				saw_white = 0;
				span_start = offset + 24'd1;
				mode = MODE_QUOTED;
				if (eod) begin
					push_field(span_start, '0, 1'b1, 1'b1);
					close_row();
				end
			end else begin
				saw_white = 0;
				span_start = offset;
				mode = MODE_PLAIN;
				trim_len = 24'd1;
				if (b == CH_BSLASH) begin
					esc = 1;
					if (eod)
						drop_row();
				end else if (eod) begin
					push_field(offset, 24'd1, 1'b0, 1'b0);
					close_row();
				end
			end
		endfunction

		// Byte after a closing quote
		function void after_quote(logic [7:0] b, bit eod);
			if (is_white(b)) begin
				if (eod) begin
					push_field(span_start, trim_len, 1'b1, 1'b0);
					close_row();
				end
			end else if (b == CH_COMMA) begin
				push_field(span_start, trim_len, 1'b1, 1'b0);
				mode = MODE_EXPECT;
				saw_white = 0;
				if (eod)
					close_row();
			end else if (is_eol(b)) begin
				push_field(span_start, trim_len, 1'b1, 1'b0);
				close_row();
			end else begin
				// Missing separator: flag the quoted field, restart on this byte
				push_field(span_start, trim_len, 1'b1, 1'b1);
				mode = MODE_EXPECT;
				saw_white = 0;
				if (eod) begin
					if (b == CH_BSLASH)
						drop_row();
					else
						close_row();
				end else begin
					begin_field(b, 1'b0);
				end
			end
		endfunction

		function void plain_byte(logic [7:0] b, bit eod);
			logic [23:0] incl;
			incl = offset - span_start + 24'd1;
			if (!esc && (b == CH_COMMA || is_eol(b))) begin
				push_field(span_start, trim_len, 1'b0, 1'b0);
				if (b == CH_COMMA) begin
					mode = MODE_EXPECT;
					saw_white = 0;
					if (eod)
						close_row();
				end else begin
					close_row();
				end
			end else begin
				if (!is_white(b))
					trim_len = incl;
				if (!esc && b == CH_BSLASH) begin
					esc = 1;
					if (eod)
						drop_row();
				end else begin
					esc = 0;
					if (eod) begin
						push_field(span_start, trim_len, 1'b0, 1'b0);
						close_row();
					end
				end
			end
		endfunction

		function void quoted_byte(logic [7:0] b, bit eod);
			logic [23:0] here;
			bit          content;
			here = offset - span_start;
			content = 0;
			if (esc) begin
				esc = 0;
				content = 1;
			end else if (b == CH_QUOTE) begin
				trim_len = here;
				mode = MODE_QUOTE_SEEN;
				if (eod) begin
					push_field(span_start, here, 1'b1, 1'b0);
					close_row();
				end
			end else if (is_eol(b)) begin
				push_field(span_start, here, 1'b1, 1'b1);
				close_row();
			end else if (b == CH_BSLASH) begin
				esc = 1;
				if (eod)
					drop_row();
			end else begin
				content = 1;
			end
			// Buffer ends inside the quotes: report it unclosed
			if (content && eod) begin
				push_field(span_start, here + 24'd1, 1'b1, 1'b1);
				close_row();
			end
		endfunction

		function void quote_seen_byte(logic [7:0] b, bit eod);
			if (b == CH_QUOTE) begin
				mode = MODE_QUOTED;
				if (eod) begin
					push_field(span_start, offset - span_start + 24'd1, 1'b1, 1'b1);
					close_row();
				end
			end else begin
				mode = MODE_AFTER_QUOTE;
				after_quote(b, eod);
			end
		endfunction

		// Advance the tokenizer by one accepted byte and queue its tokens
		function void note_byte(in_item_t it);
			int        queued;
			out_item_t t;
			queued = expected_tokens.size();
			case (mode)
				MODE_PLAIN:       plain_byte(it.data_byte, it.end_of_data);
				MODE_QUOTED:      quoted_byte(it.data_byte, it.end_of_data);
				MODE_QUOTE_SEEN:  quote_seen_byte(it.data_byte, it.end_of_data);
				MODE_AFTER_QUOTE: after_quote(it.data_byte, it.end_of_data);
				default: begin
					mode = MODE_EXPECT;
					esc = 0;
					begin_field(it.data_byte, it.end_of_data);
				end
			endcase
			offset = it.end_of_data ? 24'd0 : offset + 24'd1;
			if (expected_tokens.size() > queued) begin
				t = expected_tokens.pop_back();
				t.last_of_run = 1'b1;
				expected_tokens.push_back(t);
			end
		endfunction

		function void compare(string name, logic [23:0] want, logic [23:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// Check one accepted token against the oldest prediction
		function void check_token(out_item_t got);
			out_item_t want;
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: kind %0d start %0d length %0d",
					got.kind, got.field_start, got.field_length);
				mismatches++;
			end else begin
				want = expected_tokens.pop_front();
				compare("kind", want.kind, got.kind);
				compare("field_start", want.field_start, got.field_start);
				compare("field_length", want.field_length, got.field_length);
				compare("null_field", want.null_field, got.null_field);
				compare("was_quoted", want.was_quoted, got.was_quoted);
				compare("leading_nulls", want.leading_nulls, got.leading_nulls);
				compare("malformed", want.malformed, got.malformed);
				compare("last_of_run", want.last_of_run, got.last_of_run);
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_item = '0;
	logic      tok_valid;
	logic      tok_stall = 1'b0;
	out_item_t tok_item;

	token_scoreboard sb;
	int sent_items = 0;
	int send_idle = 0;
	int stall_pct = 0;

	csv_field_tokenizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_item   (tok_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the token side at random
	always @(posedge clk) begin
		tok_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);
	end

	// Predict on every accepted byte, check every accepted token
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall)
				sb.note_byte(byte_item);
			if (tok_valid && !tok_stall)
				sb.check_token(tok_item);
		end
	end

	// Offer one byte, hold it until accepted, then idle at random
	task automatic put_byte(input logic [7:0] b, input bit eod);
		in_item_t it;
		int       gap;
		it.data_byte = b;
		it.end_of_data = eod;
		byte_valid <= 1'b1;
		byte_item <= it;
		do @(posedge clk); while (byte_stall);
		sent_items++;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < send_idle)
			gap++;
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 7))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return 8'($urandom_range(128, 255));
			3: return 8'($urandom_range(48, 57));
			default: return 8'($urandom_range(97, 122));
		endcase
	endfunction

	function automatic logic [7:0] special_char();
		case ($urandom_range(0, 7))
			0: return CH_COMMA;
			1: return CH_QUOTE;
			2: return CH_BSLASH;
			3: return CH_SPACE;
			4: return CH_TAB;
			5: return CH_LF;
			6: return CH_CR;
			default: return CH_NUL;
		endcase
	endfunction

	// Build one mostly well-formed row with random content and send it
	task automatic emit_row();
		logic [7:0] row_q[$];
		int         nf;
		int         k;
		int         n;
		bit         eod_end;
		eod_end = 0;
		nf = $urandom_range(1, 4);
		for (int f = 0; f < nf; f++) begin
			if (f != 0)
				row_q.push_back(CH_COMMA);
			k = $urandom_range(0, 9);
			if (k == 9) begin
				repeat ($urandom_range(1, 2)) row_q.push_back(CH_SPACE);
			end else if (k != 0) begin
				repeat ($urandom_range(0, 1))
					row_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
				if (k <= 5) begin
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(0, 5) == 0) begin
							row_q.push_back(CH_BSLASH);
							row_q.push_back(8'($urandom_range(0, 255)));
						end else begin
							row_q.push_back(text_char());
						end
					end
				end else begin
					row_q.push_back(CH_QUOTE);
					n = $urandom_range(0, 5);
					for (int i = 0; i < n; i++) begin
						case ($urandom_range(0, 9))
							0: begin
								row_q.push_back(CH_QUOTE);
								row_q.push_back(CH_QUOTE);
							end
							1: row_q.push_back(CH_COMMA);
							2: begin
								row_q.push_back(CH_BSLASH);
								row_q.push_back(8'($urandom_range(0, 255)));
							end
							3: row_q.push_back($urandom_range(0, 3) == 0 ? CH_LF : CH_COMMA);
							default: row_q.push_back(text_char());
						endcase
					end
					// Leave some quotes unclosed, follow some with stray text
					if ($urandom_range(0, 19) != 0)
						row_q.push_back(CH_QUOTE);
					if ($urandom_range(0, 9) == 0)
						row_q.push_back(8'($urandom_range(97, 122)));
				end
				repeat ($urandom_range(0, 1)) row_q.push_back(CH_SPACE);
			end
		end
		// Terminate the row
		case ($urandom_range(0, 11))
			0, 1, 2, 3: row_q.push_back(CH_LF);
			4: begin
				row_q.push_back(CH_CR);
				row_q.push_back(CH_LF);
			end
			5: row_q.push_back(CH_NUL);
			6: begin
				row_q.push_back(CH_COMMA);
				row_q.push_back(CH_LF);
			end
			7: begin
				row_q.push_back(CH_BSLASH);
				eod_end = 1;
			end
			default: begin
				if (row_q.size() == 0)
					row_q.push_back(text_char());
				eod_end = 1;
			end
		endcase
		foreach (row_q[i])
			put_byte(row_q[i], eod_end && i == row_q.size() - 1);
	endtask

	task automatic emit_noise();
		repeat ($urandom_range(1, 8))
			put_byte($urandom_range(0, 1) ? special_char() : 8'($urandom_range(0, 255)),
				$urandom_range(0, 7) == 0);
	endtask

	task automatic run_phase(input int items, input int idle, input int stall);
		int target;
		send_idle = idle;
		stall_pct = stall;
		target = sent_items + items;
		while (sent_items < target) begin
			if ($urandom_range(0, 4) == 0)
				emit_noise();
			else
				emit_row();
		end
	endtask

	task automatic directed();
		// Null-only row, then a leading null and a trailing comma
		put_byte(CH_COMMA, 0);
		put_byte(CH_COMMA, 0);
		put_byte(CH_LF, 0);
		put_byte(CH_COMMA, 0);
		put_byte("a", 0);
		put_byte(CH_COMMA, 0);
		put_byte(CH_LF, 0);
		// White then row end
		put_byte(CH_SPACE, 0);
		put_byte(CH_TAB, 0);
		put_byte(CH_CR, 0);
		// Top byte value, trimmed white, zero byte as terminator
		put_byte(8'hFF, 0);
		put_byte(CH_SPACE, 0);
		put_byte(CH_NUL, 0);
		// Doubled quote, then unclosed at row end
		put_byte(CH_QUOTE, 0);
		put_byte("a", 0);
		put_byte(CH_QUOTE, 0);
		put_byte(CH_QUOTE, 0);
		put_byte(CH_LF, 0);
		// Closing quote as the buffer's last byte
		put_byte(CH_QUOTE, 0);
		put_byte("b", 0);
		put_byte(CH_QUOTE, 1);
		// Stray byte after a quote, then escape at the buffer end
		put_byte(CH_QUOTE, 0);
		put_byte(CH_QUOTE, 0);
		put_byte("x", 0);
		put_byte(CH_BSLASH, 1);
		// Lone escape and lone white as the buffer's last byte
		put_byte(CH_BSLASH, 1);
		put_byte(CH_SPACE, 1);
	endtask

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int guard;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		// Saturate the leading null count
		repeat (258) put_byte(CH_COMMA, 0);
		put_byte("x", 0);
		put_byte(CH_LF, 0);
		run_phase(200, 0, 0);
		run_phase(200, 53, 0);
		run_phase(200, 0, 53);
		run_phase(200, 38, 38);
		byte_valid <= 1'b0;
		// Drain outstanding tokens, then let the pipeline settle
		guard = 0;
		while (sb.expected_tokens.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (sb.expected_tokens.size() != 0) begin
			$error("%0d expected tokens never arrived", sb.expected_tokens.size());
			sb.mismatches++;
		end
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
src/ctf_pkg.sv
src/ctf_parser.sv
src/ctf_res_fifo.sv
src/csv_field_tokenizer.sv
sim/tb_csv_field_tokenizer.sv
